// ===== rtl/ielr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ielr_pkg
// Types and constants shared by the edge line rasterizer modules.
// ----------------------------------------------------------------------------
package ielr_pkg;
  localparam int POS_W   = 34;
  localparam int PIX_W   = 18;
  localparam int COLOR_W = 24;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int HGT_W   = 11;
  localparam int ZOOM_W  = 7;
  localparam int SH_W    = 13;

  localparam logic [COLOR_W-1:0] RED_RGB   = 24'he80c0c;
  localparam logic [COLOR_W-1:0] WHITE_RGB = 24'hffffff;
  localparam logic [63:0] COS_Q32 = 64'd3284972181;
  localparam logic [63:0] SIN_Q32 = 64'd2766893898;

  localparam logic [CFG_IDX_W-1:0] REG_ZOOM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOFF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFTX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFTY = 2'd3;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SUM, ST_DIFF, ST_DIV, ST_RUN
  } back_state_t;
endpackage
`default_nettype wire

// ===== rtl/ielr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ielr_in_if / ielr_out_if
// Valid/ready channels for edge items and pixel words.
// ----------------------------------------------------------------------------
interface ielr_in_if #(parameter int GRID_BITS = 10);
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [GRID_BITS-1:0]        start_col;
  logic [GRID_BITS-1:0]        start_row;
  logic [GRID_BITS-1:0]        end_col;
  logic [GRID_BITS-1:0]        end_row;
  logic signed [10:0]          start_height;
  logic signed [10:0]          end_height;
  modport source (output valid, func, start_col, start_row, end_col, end_row,
                  start_height, end_height, input ready);
  modport sink (input valid, func, start_col, start_row, end_col, end_row,
                start_height, end_height, output ready);
endinterface

interface ielr_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] pixel_x;
  logic signed [17:0] pixel_y;
  logic [23:0]        pixel_color;
  logic               last_pixel;
  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, last_pixel,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/ielr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ielr_queue
// Two-entry FIFO between the front and the back part.
// ----------------------------------------------------------------------------
module ielr_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_valid,
  output logic              wr_ready,
  input  wire logic [W-1:0] wr_data,
  output logic              rd_valid,
  input  wire logic         rd_ready,
  output logic [W-1:0]      rd_data
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ielr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ielr_front
// Accepts items, adjusts heights, picks the edge color and scales the grid.
// ----------------------------------------------------------------------------
module ielr_front
  import ielr_pkg::*;
#(
  parameter int GRID_BITS = 10,
  parameter int ZG_W = GRID_BITS + ZOOM_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  ielr_in_if.sink                     in_ch,
  input  wire logic [ZOOM_W-1:0]      zoom,
  input  wire logic signed [HGT_W-1:0] hoff,
  output logic                        q_valid,
  input  wire logic                   q_ready,
  output logic [2*HGT_W+4*ZG_W+COLOR_W+2:0] q_data
);
  logic signed [HGT_W:0] hs, he;
  logic [COLOR_W-1:0]    col;
  logic [ZG_W-1:0]       zsc, zsr, zec, zer;

  always_comb begin
    hs = (in_ch.start_height != '0) ?
         (HGT_W+1)'(in_ch.start_height) + (HGT_W+1)'(hoff) : '0;
    he = (in_ch.end_height != '0) ?
         (HGT_W+1)'(in_ch.end_height) + (HGT_W+1)'(hoff) : '0;
    col = (hs > 0 || he > 0) ? RED_RGB : WHITE_RGB;
    zsc = ZG_W'(in_ch.start_col) * ZG_W'(zoom);
    zsr = ZG_W'(in_ch.start_row) * ZG_W'(zoom);
    zec = ZG_W'(in_ch.end_col) * ZG_W'(zoom);
    zer = ZG_W'(in_ch.end_row) * ZG_W'(zoom);
  end

  // adjusted heights need 12 bits
  assign in_ch.ready = q_ready;
  assign q_valid = in_ch.valid;
  assign q_data = {in_ch.func, hs, he, zsc, zsr, zec, zer, col};
endmodule
`default_nettype wire

// ===== rtl/ielr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ielr_back
// Projects the edge, divides for DDA steps and walks pixels.
// ----------------------------------------------------------------------------
module ielr_back
  import ielr_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int GRID_BITS = 10,
  parameter int ZG_W = GRID_BITS + ZOOM_W
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    q_valid,
  output logic                         q_ready,
  input  wire logic [2*HGT_W+4*ZG_W+COLOR_W+2:0] q_data,
  input  wire logic signed [SH_W-1:0]  shx,
  input  wire logic signed [SH_W-1:0]  shy,
  ielr_out_if.source                   out_ch,
  output logic                         busy
);
  localparam int QW = FRAC_BITS + 1;
  localparam int SW = PIX_W;
  localparam int DW = POS_W + 1;
  localparam int PM_W = ZG_W + FRAC_BITS + 2;
  localparam int DC_W = $clog2(FRAC_BITS + 1);
  localparam logic [63:0] CQ = (COS_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic [63:0] SQ = (SIN_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic [FRAC_BITS:0] CQ_N = CQ[FRAC_BITS:0];
  localparam logic [FRAC_BITS:0] SQ_N = SQ[FRAC_BITS:0];
  localparam logic [DW-1:0] ONE = DW'(64'd1 << FRAC_BITS);

  back_state_t st_r, st_nxt;

  logic                  func;
  logic signed [HGT_W:0] hs, he;
  logic [ZG_W-1:0]       zsc, zsr, zec, zer;
  logic [COLOR_W-1:0]    col;

  logic signed [POS_W-1:0] ax_r, ay_r, bx_r, by_r;
  logic signed [POS_W-1:0] cx_r, cy_r, tx_r, ty_r;
  logic signed [SW-1:0]    sx_r, sy_r;
  logic [COLOR_W-1:0]      col_r, ecol_r;
  logic signed [HGT_W:0]   hs_r, he_r;
  logic [DW-1:0]           big_r, rx_r, ry_r;
  logic                    nx_r, ny_r;
  logic [QW-1:0]           qx_r, qy_r;
  logic [DC_W-1:0]         dc_r;
  logic                    ov_r;

  logic signed [DW-1:0]    dx, dy, ndx, ndy;
  logic signed [POS_W-1:0] ncx, ncy;
  logic [DW-1:0]           mdx, mdy;
  logic                    far_c, far_n;

  logic signed [ZG_W:0]    ddx_s, ddx_e;
  logic [ZG_W:0]           sm_s, sm_e;
  logic signed [PM_W-1:0]  pxs, pxe;
  logic [PM_W-1:0]         pys, pye;

  assign {func, hs, he, zsc, zsr, zec, zer, col} = q_data;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    mag = v[DW-1] ? DW'(-v) : v;
  endfunction

  function automatic logic signed [PIX_W-1:0] trunc_pix(input logic signed [POS_W-1:0] v);
    logic signed [POS_W-1:0] t;
    t = v[POS_W-1] ? v + POS_W'(ONE - 1) : v;
    trunc_pix = PIX_W'(t >>> FRAC_BITS);
  endfunction

  always_comb begin
    ddx_s = $signed({1'b0, zsc}) - $signed({1'b0, zsr});
    ddx_e = $signed({1'b0, zec}) - $signed({1'b0, zer});
    sm_s  = {1'b0, zsc} + {1'b0, zsr};
    sm_e  = {1'b0, zec} + {1'b0, zer};
    pxs   = ddx_s * $signed(CQ_N);
    pxe   = ddx_e * $signed(CQ_N);
    pys   = sm_s * SQ_N;
    pye   = sm_e * SQ_N;
  end

  always_comb begin
    dx  = DW'(tx_r) - DW'(cx_r);
    dy  = DW'(ty_r) - DW'(cy_r);
    far_c = mag(dx) >= ONE || mag(dy) >= ONE;
    ncx = cx_r + POS_W'(sx_r);
    ncy = cy_r + POS_W'(sy_r);
    ndx = DW'(tx_r) - DW'(ncx);
    ndy = DW'(ty_r) - DW'(ncy);
    far_n = mag(ndx) >= ONE || mag(ndy) >= ONE;
    mdx = mag(dx);
    mdy = mag(dy);
  end

  logic act_r;
  logic out_free;
  assign out_free = !out_ch.valid || out_ch.ready;

  always_comb begin
    st_nxt  = st_r;
    q_ready = 1'b0;
    unique case (st_r)
      ST_IDLE, ST_RUN: begin
        if (q_valid) begin
          if (func == FUNC_START) begin
            q_ready = 1'b1;
            st_nxt  = ST_MUL;
          end else if (!act_r || !far_c) begin
            q_ready = 1'b1;
          end else if (out_free) begin
            q_ready = 1'b1;
          end
        end
      end
      ST_MUL:  st_nxt = ST_SUM;
      ST_SUM:  st_nxt = ST_DIFF;
      ST_DIFF: st_nxt = ST_DIV;
      ST_DIV:  if (dc_r == DC_W'(FRAC_BITS) || ov_r) st_nxt = ST_RUN;
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign busy = (st_r != ST_IDLE && st_r != ST_RUN) || q_valid || out_ch.valid;

  logic step_take;
  assign step_take = (st_r == ST_IDLE || st_r == ST_RUN) && q_valid &&
                     func == FUNC_STEP && act_r && far_c && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      act_r <= 1'b0;
      cx_r <= '0; cy_r <= '0; tx_r <= '0; ty_r <= '0;
      sx_r <= '0; sy_r <= '0;
      ecol_r <= WHITE_RGB;
      out_ch.valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (st_r)
        ST_IDLE, ST_RUN: begin
          if (q_valid && q_ready) begin
            if (func == FUNC_START) begin
              act_r <= 1'b0;
              ax_r <= POS_W'(pxs);
              ay_r <= POS_W'(pys);
              bx_r <= POS_W'(pxe);
              by_r <= POS_W'(pye);
              hs_r <= hs; he_r <= he; col_r <= col;
            end else if (step_take) begin
              out_ch.valid       <= 1'b1;
              out_ch.pixel_x     <= trunc_pix(cx_r);
              out_ch.pixel_y     <= trunc_pix(cy_r);
              out_ch.pixel_color <= ecol_r;
              out_ch.last_pixel  <= !far_n;
              cx_r <= ncx; cy_r <= ncy;
              if (!far_n) act_r <= 1'b0;
            end else begin
              act_r <= 1'b0;
            end
          end
        end
        ST_MUL: begin
          cx_r <= ax_r + (POS_W'(shx) << FRAC_BITS);
          cy_r <= ay_r - (POS_W'(hs_r) << FRAC_BITS) + (POS_W'(shy) << FRAC_BITS);
          tx_r <= bx_r + (POS_W'(shx) << FRAC_BITS);
          ty_r <= by_r - (POS_W'(he_r) << FRAC_BITS) + (POS_W'(shy) << FRAC_BITS);
          ecol_r <= col_r;
        end
        ST_SUM: begin
          big_r <= (mdx > mdy) ? mdx : mdy;
          rx_r <= mdx; ry_r <= mdy;
          nx_r <= dx[DW-1]; ny_r <= dy[DW-1];
          act_r <= far_c;
        end
        ST_DIFF: begin
          qx_r <= '0; qy_r <= '0; dc_r <= '0;
          ov_r <= (big_r == '0);
          if (big_r != '0) begin
            if (rx_r >= big_r) begin qx_r <= QW'(ONE); rx_r <= '0; end
            if (ry_r >= big_r) begin qy_r <= QW'(ONE); ry_r <= '0; end
          end
        end
        ST_DIV: begin
          if (!ov_r && dc_r != DC_W'(FRAC_BITS)) begin
            dc_r <= dc_r + 1'b1;
            // a major axis already holds its full step
            if (!qx_r[QW-1]) begin
              if ({rx_r, 1'b0} >= {1'b0, big_r}) begin
                rx_r <= DW'({rx_r, 1'b0} - {1'b0, big_r});
                qx_r <= {qx_r[QW-2:0], 1'b1};
              end else begin
                rx_r <= rx_r << 1;
                qx_r <= {qx_r[QW-2:0], 1'b0};
              end
            end
            if (!qy_r[QW-1]) begin
              if ({ry_r, 1'b0} >= {1'b0, big_r}) begin
                ry_r <= DW'({ry_r, 1'b0} - {1'b0, big_r});
                qy_r <= {qy_r[QW-2:0], 1'b1};
              end else begin
                ry_r <= ry_r << 1;
                qy_r <= {qy_r[QW-2:0], 1'b0};
              end
            end
          end
          if (st_nxt == ST_RUN) begin
            sx_r <= nx_r ? -SW'(qx_r) : SW'(qx_r);
            sy_r <= ny_r ? -SW'(qy_r) : SW'(qy_r);
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/isometric_edge_line_rasterizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isometric_edge_line_rasterizer
// Projects a grid edge isometrically and walks its pixels with a DDA.
//
//  channel | dir | fields
//  in_     | in  | func, start/end col/row, start/end height
//  out_    | out | pixel_x, pixel_y, pixel_color, last_pixel
//  cfg_    | in  | we, idx, data (zoom, height offset, shift x/y)
//
// Step words are taken while the output register is free; a start word holds
// the back part through ST_MUL, ST_SUM, ST_DIFF and the one-bit-a-cycle ST_DIV step divider.
// Synchronous active-low reset; no clearing pass.
// A pixel held in the output register stalls the next step word; the queue
// still takes up to two words.
// ----------------------------------------------------------------------------
module isometric_edge_line_rasterizer
  import ielr_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int GRID_BITS = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  ielr_in_if.sink                 in_ch,
  ielr_out_if.source              out_ch,
  input  wire logic               cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]   cfg_data
);
  localparam int ZG_W = GRID_BITS + ZOOM_W;
  localparam int QD_W = 2*HGT_W + 4*ZG_W + COLOR_W + 3;

  logic [ZOOM_W-1:0]      zoom_r;
  logic signed [HGT_W-1:0] hoff_r;
  logic signed [SH_W-1:0] shx_r, shy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zoom_r <= ZOOM_W'(20);
      hoff_r <= '0;
      shx_r  <= SH_W'(400);
      shy_r  <= SH_W'(300);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ZOOM:   zoom_r <= cfg_data[ZOOM_W-1:0];
        REG_HOFF:   hoff_r <= cfg_data[HGT_W-1:0];
        REG_SHIFTX: shx_r  <= cfg_data;
        REG_SHIFTY: shy_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic            fq_valid, fq_ready, bq_valid, bq_ready, busy;
  logic [QD_W-1:0] fq_data, bq_data;

  ielr_front #(.GRID_BITS(GRID_BITS)) u_front (
    .clk, .rst_n, .in_ch, .zoom(zoom_r), .hoff(hoff_r),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data));

  ielr_queue #(.W(QD_W)) u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data));

  ielr_back #(.FRAC_BITS(FRAC_BITS), .GRID_BITS(GRID_BITS)) u_back (
    .clk, .rst_n, .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
    .shx(shx_r), .shy(shy_r), .out_ch, .busy);

`ifndef NO_ASSERTIONS
  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.pixel_color == RED_RGB || out_ch.pixel_color == WHITE_RGB))
    else $error("bad pixel color");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.pixel_x))
    else $error("pixel dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> busy)
    else $error("busy low with pending pixel");
`endif
endmodule
`default_nettype wire
